[hdl/tgarle_pkg.sv]
`timescale 1ns / 1ps

package tgarle_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam int unsigned ADDR_W = 3;

	localparam logic REG_BPP   = 1'b0;
	localparam logic REG_TOTAL = 1'b1;

	localparam logic [2:0]  BPP_RESET   = 3'd4;
	localparam logic [24:0] TOTAL_RESET = 25'd1;
	localparam logic [2:0]  BPP_24      = 3'd3;

	localparam logic [7:0] RUN_BIAS = 8'd127;

	typedef struct packed {
		logic        size3;
		logic [24:0] total;
	} cfg_t;

	// one complete pixel's worth of work for the emitter
	typedef struct packed {
		logic [31:0] pix;
		logic [7:0]  count;
		logic        over;
		logic        idone;
	} job_t;

endpackage

[hdl/tgarle_if.sv]
`timescale 1ns / 1ps

interface tgarle_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source(output valid, output byte_in, input ready);
	modport sink(input valid, input byte_in, output ready);
endinterface

interface tgarle_pix_if;
	logic        valid;
	logic        ready;
	logic [31:0] pixel_first;
	logic [31:0] pixel_second;
	logic [1:0]  pixels_valid;
	logic        last_of_packet;
	logic        image_done;
	logic        overrun_error;

	modport source(output valid, output pixel_first, output pixel_second,
		output pixels_valid, output last_of_packet, output image_done,
		output overrun_error, input ready);
	modport sink(input valid, input pixel_first, input pixel_second,
		input pixels_valid, input last_of_packet, input image_done,
		input overrun_error, output ready);
endinterface

[hdl/tgarle_regs.sv]
`timescale 1ns / 1ps

module tgarle_regs #(
	parameter int unsigned MAX_PIXELS = 16777216
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tgarle_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output tgarle_pkg::cfg_t                cfg
);
	import tgarle_pkg::*;

	logic [2:0]  bpp_q;
	logic [24:0] total_q;
	logic        idx;
	logic        wr;

	assign idx = paddr[ADDR_W-1];
	assign wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q   <= BPP_RESET;
			total_q <= TOTAL_RESET;
		end else if (wr) begin
			case (idx)
				REG_BPP:   bpp_q   <= pwdata[2:0];
				REG_TOTAL: total_q <= pwdata[24:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BPP:   prdata = {29'd0, bpp_q};
			REG_TOTAL: prdata = {7'd0, total_q};
			default:   prdata = 32'd0;
		endcase
	end

	assign cfg.size3 = (bpp_q == BPP_24);
	assign cfg.total = ({7'd0, total_q} < 32'(MAX_PIXELS)) ? total_q : 25'(MAX_PIXELS);

endmodule

[hdl/tgarle_front.sv]
`timescale 1ns / 1ps

module tgarle_front (
	input  logic             clk,
	input  logic             arst_n,
	input  tgarle_pkg::cfg_t cfg,
	input  logic             valid,
	input  logic [7:0]       byte_in,
	output logic             ready,
	input  logic             q_full,
	output logic             q_push,
	output tgarle_pkg::job_t job
);
	import tgarle_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_RAW    = 3'b010,
		PH_RUN    = 3'b100
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  rem_q;
	logic [1:0]  bip_q;
	logic [31:0] asm_q;
	logic [24:0] done_q;

	logic        beat;
	logic [1:0]  bip_nx;
	logic [31:0] asm_nx;
	logic        complete;
	logic [7:0]  copies;
	logic [24:0] avail;
	logic        fits;
	logic [7:0]  k;
	logic [24:0] sum;
	logic [7:0]  rem_nx;

	assign ready = !q_full;
	assign beat  = valid && ready;

	always_comb begin
		bip_nx   = bip_q + 2'd1;
		asm_nx   = (bip_q == 2'd0) ? {24'd0, byte_in}
			: (asm_q | ({24'd0, byte_in} << {bip_q, 3'b000}));
		complete = (bip_nx == 2'd0) || (cfg.size3 && bip_nx == 2'd3);
		copies   = (phase_q == PH_RAW) ? 8'd1 : rem_q;
		avail    = (done_q >= cfg.total) ? 25'd0 : cfg.total - done_q;
		fits     = {17'd0, copies} <= avail;
		k        = fits ? copies : avail[7:0];
		sum      = done_q + {17'd0, copies};
		rem_nx   = (phase_q == PH_RAW) ? rem_q - 8'd1 : 8'd0;

		job.pix   = {(cfg.size3 ? 8'd0 : asm_nx[31:24]), asm_nx[7:0], asm_nx[15:8],
			asm_nx[23:16]};
		job.count = k;
		job.over  = !fits;
		job.idone = (k != 8'd0) && ({17'd0, k} == avail);
		q_push    = beat && complete && (phase_q == PH_RAW || phase_q == PH_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			rem_q   <= 8'd0;
			bip_q   <= 2'd0;
			asm_q   <= 32'd0;
			done_q  <= 25'd0;
		end else if (beat) begin
			case (phase_q)
				PH_HEADER: begin
					phase_q <= byte_in[7] ? PH_RUN : PH_RAW;
					rem_q   <= byte_in[7] ? byte_in - RUN_BIAS : byte_in + 8'd1;
					bip_q   <= 2'd0;
					asm_q   <= 32'd0;
				end
				PH_RAW, PH_RUN: begin
					asm_q <= asm_nx;
					bip_q <= complete ? 2'd0 : bip_nx;
					if (complete) begin
						if (!fits) begin
							phase_q <= PH_HEADER;
							rem_q   <= 8'd0;
							done_q  <= 25'd0;
						end else begin
							rem_q  <= rem_nx;
							done_q <= sum;
							if (rem_nx == 8'd0) begin
								phase_q <= PH_HEADER;
								if (sum >= cfg.total) done_q <= 25'd0;
							end
						end
					end
				end
				default: phase_q <= PH_HEADER;
			endcase
		end
	end

endmodule

[hdl/tgarle_fifo.sv]
`timescale 1ns / 1ps

module tgarle_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tgarle_pkg::job_t wdata,
	input  logic             pop,
	output tgarle_pkg::job_t rdata,
	output logic             full,
	output logic             empty
);
	import tgarle_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[hdl/tgarle_back.sv]
`timescale 1ns / 1ps

module tgarle_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tgarle_pkg::job_t head,
	input  logic             q_empty,
	output logic             q_pop,
	output logic             valid,
	input  logic             ready,
	output logic [31:0]      pixel_first,
	output logic [31:0]      pixel_second,
	output logic [1:0]       pixels_valid,
	output logic             last_of_packet,
	output logic             image_done,
	output logic             overrun_error
);
	import tgarle_pkg::*;

	logic        cur_v_q;
	job_t        cur_q;
	logic [7:0]  left_q;
	logic        o_v_q;

	logic        can_emit;
	logic [1:0]  nv;
	logic        last;
	logic        load;

	assign can_emit = cur_v_q && (!o_v_q || ready);
	assign nv       = (left_q >= 8'd2) ? 2'd2 : left_q[1:0];
	assign last     = (left_q <= 8'd2);
	assign load     = !q_empty && (!cur_v_q || (can_emit && last));
	assign q_pop    = load;
	assign valid    = o_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			o_v_q   <= 1'b0;
		end else begin
			if (can_emit)   o_v_q <= 1'b1;
			else if (ready) o_v_q <= 1'b0;
			if (load)                  cur_v_q <= 1'b1;
			else if (can_emit && last) cur_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q  <= head;
			left_q <= head.count;
		end else if (can_emit) begin
			left_q <= left_q - {6'd0, nv};
		end
		if (can_emit) begin
			pixel_first    <= (nv != 2'd0) ? cur_q.pix : 32'd0;
			pixel_second   <= (nv == 2'd2) ? cur_q.pix : 32'd0;
			pixels_valid   <= nv;
			last_of_packet <= last;
			image_done     <= last && cur_q.idone;
			overrun_error  <= last && cur_q.over;
		end
	end

endmodule

[hdl/tga_rle_pixel_decoder_unit.sv]
`timescale 1ns / 1ps

// Run-length TGA pixel decoder, 24/32 bpp. Bytes are taken one per cycle while
// the four-entry pixel queue has room; header and partial-pixel bytes give no
// result. The first result of a pixel passes the queue, the emitter's job
// register and its output register. The emitter sends one result (up to two
// pixels) per cycle while the sink is ready, so a run of n pixels leaves as
// ceil(n/2) results, while each pixel of a raw packet leaves as a result of
// its own; an overrun packet ends with its error flag on the last result. While
// a 128-pixel run is emitted, the front keeps decoding until the queue is full.
module tga_rle_pixel_decoder_unit #(
	parameter int unsigned MAX_PIXELS = 16777216
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tgarle_byte_if.sink                   in_bytes,
	tgarle_pix_if.source                  out_pixels,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tgarle_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import tgarle_pkg::*;

	cfg_t cfg;
	job_t job_w;
	job_t head;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;

	assign pready = 1'b1;

	tgarle_regs #(.MAX_PIXELS(MAX_PIXELS)) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tgarle_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.valid   (in_bytes.valid),
		.byte_in (in_bytes.byte_in),
		.ready   (in_bytes.ready),
		.q_full  (q_full),
		.q_push  (q_push),
		.job     (job_w)
	);

	tgarle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (job_w),
		.pop    (q_pop),
		.rdata  (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	tgarle_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.valid          (out_pixels.valid),
		.ready          (out_pixels.ready),
		.pixel_first    (out_pixels.pixel_first),
		.pixel_second   (out_pixels.pixel_second),
		.pixels_valid   (out_pixels.pixels_valid),
		.last_of_packet (out_pixels.last_of_packet),
		.image_done     (out_pixels.image_done),
		.overrun_error  (out_pixels.overrun_error)
	);

endmodule

[tb/pixel_beat_checker.sv]
`timescale 1ns / 1ps

module pixel_beat_checker #(
	parameter int unsigned MAX_PIXELS = 16777216
) (
	input  logic                          clk,
	input  logic                          arst_n,
	tgarle_byte_if                        byte_mon,
	tgarle_pix_if                         pix_mon,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tgarle_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          pready,
	output int unsigned                   beat_errors,
	output int unsigned                   beats_owed
);
	import tgarle_pkg::*;

	typedef enum logic [1:0] {AWAIT_HEADER, RAW_PIXELS, RUN_PIXELS} pkt_phase_t;

	typedef struct packed {
		logic [31:0] pix_a;
		logic [31:0] pix_b;
		logic [1:0]  npix;
		logic        last;
		logic        idone;
		logic        over;
	} pix_beat_t;

	localparam logic [ADDR_W-1:0] BPP_ADDR   = {REG_BPP, 2'b00};
	localparam logic [ADDR_W-1:0] TOTAL_ADDR = {REG_TOTAL, 2'b00};

	logic [2:0]  cfg_bpp;
	logic [24:0] cfg_total;

	pkt_phase_t  phase;
	logic [7:0]  run_left;
	logic [1:0]  byte_slot;
	logic [31:0] gather;
	logic [24:0] image_count;

	pix_beat_t   pending_beats[$];
	int unsigned n_fail;

	task automatic decode_byte(input logic [7:0] b);
		pix_beat_t   beats[0:64];
		int          n;
		logic [2:0]  size;
		logic [31:0] pix;
		logic [7:0]  copies;
		logic [24:0] limit;
		logic        over;
		logic        half;
		n = 0;
		over = 1'b0;
		half = 1'b0;
		if (phase == AWAIT_HEADER) begin
			if (b < 8'd128) begin
				phase = RAW_PIXELS;
				run_left = b + 8'd1;
			end else begin
				phase = RUN_PIXELS;
				run_left = b - RUN_BIAS;
			end
			byte_slot = 2'd0;
			gather = '0;
			return;
		end

		if (byte_slot == 2'd0)
			gather = {24'd0, b};
		else
			gather = gather | (32'(b) << (8 * byte_slot));
		byte_slot = byte_slot + 2'd1;

		size = (cfg_bpp == BPP_24) ? 3'd3 : 3'd4;
		if (byte_slot != 2'd0 && {1'b0, byte_slot} < size)
			return;
		byte_slot = 2'd0;

		// BGR(A) in, RGB(A) out
		pix = {(size == 3'd4) ? gather[31:24] : 8'd0, gather[7:0], gather[15:8], gather[23:16]};

		if (phase == RAW_PIXELS) begin
			copies = 8'd1;
			run_left = run_left - 8'd1;
		end else begin
			copies = run_left;
			run_left = 8'd0;
		end

		limit = (cfg_total < MAX_PIXELS) ? cfg_total : 25'(MAX_PIXELS);
		for (int i = 0; i < copies; i++) begin
			if (image_count >= limit) begin
				over = 1'b1;
				break;
			end
			image_count = image_count + 25'd1;
			if (!half) begin
				beats[n] = '0;
				beats[n].pix_a = pix;
				beats[n].npix = 2'd1;
				n++;
				half = 1'b1;
			end else begin
				beats[n-1].pix_b = pix;
				beats[n-1].npix = 2'd2;
				half = 1'b0;
			end
			if (image_count == limit)
				beats[n-1].idone = 1'b1;
		end

		if (over) begin
			if (n == 0) begin
				beats[0] = '0;
				n = 1;
			end
			beats[n-1].over = 1'b1;
			phase = AWAIT_HEADER;
			run_left = 8'd0;
			byte_slot = 2'd0;
			image_count = '0;
		end
		if (n > 0)
			beats[n-1].last = 1'b1;
		if (!over && run_left == 8'd0) begin
			phase = AWAIT_HEADER;
			if (image_count >= limit)
				image_count = '0;
		end
		for (int i = 0; i < n; i++)
			pending_beats.push_back(beats[i]);
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			n_fail++;
			$display("%0t: %s expected %h, got %h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		pix_beat_t got;
		pix_beat_t want;
		if (!arst_n) begin
			cfg_bpp = BPP_RESET;
			cfg_total = TOTAL_RESET;
			phase = AWAIT_HEADER;
			run_left = '0;
			byte_slot = '0;
			gather = '0;
			image_count = '0;
			pending_beats.delete();
		end else begin
			if (pix_mon.valid && pix_mon.ready) begin
				got = '{pix_mon.pixel_first, pix_mon.pixel_second, pix_mon.pixels_valid,
					pix_mon.last_of_packet, pix_mon.image_done, pix_mon.overrun_error};
				if (pending_beats.size() == 0) begin
					n_fail++;
					$display("%0t: unexpected beat, expected none, got %h", $time, got);
				end else begin
					want = pending_beats.pop_front();
					check_field("pixel_first", want.pix_a, got.pix_a);
					check_field("pixel_second", want.pix_b, got.pix_b);
					check_field("pixels_valid", want.npix, got.npix);
					check_field("last_of_packet", want.last, got.last);
					check_field("image_done", want.idone, got.idone);
					check_field("overrun_error", want.over, got.over);
				end
			end
			if (psel && penable && pwrite && pready) begin
				if (paddr == BPP_ADDR)
					cfg_bpp = pwdata[2:0];
				else if (paddr == TOTAL_ADDR)
					cfg_total = pwdata[24:0];
			end
			if (byte_mon.valid && byte_mon.ready)
				decode_byte(byte_mon.byte_in);
		end
		beat_errors <= n_fail;
		beats_owed <= pending_beats.size();
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import tgarle_pkg::*;

	localparam int unsigned PERIOD = 4;
	localparam int unsigned SETTLE = 20;
	localparam logic [ADDR_W-1:0] BPP_ADDR   = {REG_BPP, 2'b00};
	localparam logic [ADDR_W-1:0] TOTAL_ADDR = {REG_TOTAL, 2'b00};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              sink_ready = 1'b0;
	logic              gaps_on = 1'b1;
	int unsigned       beat_errors;
	int unsigned       beats_owed;
	int unsigned       sent;
	int unsigned       px_bytes;

	tgarle_byte_if byte_ch();
	tgarle_pix_if  pix_ch();

	assign pix_ch.ready = sink_ready;

	tga_rle_pixel_decoder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_bytes  (byte_ch),
		.out_pixels(pix_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	pixel_beat_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_mon   (byte_ch),
		.pix_mon    (pix_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.beat_errors(beat_errors),
		.beats_owed (beats_owed)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		sink_ready <= !(gaps_on && ($urandom_range(0, 99) < 6));
	end

	task automatic send_byte(input logic [7:0] b);
		while (gaps_on && ($urandom_range(0, 99) < 6)) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.byte_in <= b;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic wait_beats_out();
		byte_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (beats_owed != 0);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_mode(input logic [2:0] bpp, input logic [24:0] total);
		wait_beats_out();
		repeat (SETTLE) @(posedge clk);
		apb_write(BPP_ADDR, 32'(bpp));
		apb_write(TOTAL_ADDR, 32'(total));
		px_bytes = (bpp == BPP_24) ? 3 : 4;
	endtask

	task automatic send_packet();
		int unsigned kind;
		int unsigned n;
		int unsigned cut;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			n = $urandom_range(1, 6);
			send_byte(8'(n - 1));
			repeat (n * px_bytes) send_byte(8'($urandom));
		end else if (kind < 90) begin
			send_byte(8'h80 | 8'($urandom_range(0, 127)));
			repeat (px_bytes) send_byte(8'($urandom));
		end else if (kind < 95) begin
			// packet cut short, next header lands in pixel data
			n = $urandom_range(1, 4);
			cut = $urandom_range(0, n * px_bytes - 1);
			send_byte(8'(n - 1));
			repeat (cut) send_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
		end
	endtask

	task automatic random_traffic(input int unsigned target);
		while (sent < target)
			send_packet();
	endtask

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.byte_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent = 0;
		px_bytes = 4;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 32 bpp, one-pixel image: raw, run, then a run that overruns
		set_mode(BPP_RESET, TOTAL_RESET);
		send_byte(8'h00);
		send_byte(8'h11);
		send_byte(8'h22);
		send_byte(8'h33);
		send_byte(8'h44);
		send_byte(8'h80);
		repeat (4) send_byte(8'hFF);
		send_byte(8'h81);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte(8'h0F);
		send_byte(8'hF0);

		// zero total: first pixel overruns, rest of raw packet reads as a new run packet
		set_mode(BPP_24, 25'd0);
		send_byte(8'h02);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);

		// longest run at the clamped total
		set_mode(3'd7, 25'h1FFFFFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hFF);

		set_mode(BPP_24, 25'($urandom_range(1, 12)));
		random_traffic(sent + 20);

		gaps_on <= 1'b0;
		set_mode(3'd4, 25'd16777216);
		random_traffic(sent + 20);

		gaps_on <= 1'b1;
		set_mode(3'($urandom_range(0, 7)), 25'($urandom_range(0, 40)));
		random_traffic(sent + 10);
		wait_beats_out();
		random_traffic(sent + 10);

		set_mode(BPP_24, 25'h1FFFFFF);
		random_traffic(sent + 20);

		set_mode(3'd0, 25'd1);
		random_traffic(sent + 20);

		wait_beats_out();
		repeat (SETTLE) @(posedge clk);
		if (beat_errors == 0 && beats_owed == 0)
			$display("** tga_rle_pixel_decoder_unit: PASSED **");
		else
			$display("** tga_rle_pixel_decoder_unit: FAILED **");
		$finish;
	end

	initial begin
		#(1_000_000);
		$display("** tga_rle_pixel_decoder_unit: FAILED **");
		$finish;
	end

endmodule
